// ===== design/esr_pkg.sv =====
// ----------------------------------------------------------------------------
// esr_pkg: shared definitions for the ESC pulse slew and ramp block
// Widths, reset values, request and register codes, and the control
// struct that starts the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package esr_pkg;

	localparam int FracBits = 24;
	localparam int AccW     = 36;
	localparam int PulseW   = 12;
	localparam int TimeW    = 32;
	localparam int RateW    = 24;
	localparam int DurW     = 22;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;
	localparam int IterW    = 6;

	localparam int MulAW = 24;
	localparam int MulBW = 32;
	localparam int DivNW = 34;
	localparam int DivDW = 22;
	localparam int DivQW = 32;

	localparam logic [PulseW-1:0] IdlePulse    = 12'd1000;
	localparam logic [RateW-1:0]  RateReset    = 24'd1678;
	localparam logic [PulseW-1:0] TargetReset  = 12'd1000;
	localparam logic [PulseW-1:0] InitialReset = 12'd1000;
	localparam logic [PulseW-1:0] FinalReset   = 12'd2000;
	localparam logic [DurW-1:0]   DurReset     = 22'd10000;
	localparam logic [DivDW-1:0]  UsPerMs      = 22'd1000;

	typedef enum logic [1:0] {
		MODE_SLEW  = 2'd0,
		MODE_SWEEP = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_HOLD  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_SLEW_RATE = 3'd0,
		REG_TARGET    = 3'd1,
		REG_INITIAL   = 3'd2,
		REG_FINAL     = 3'd3,
		REG_DURATION  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [IterW-1:0] iters;
	} seq_ctl_t;

endpackage

// ===== design/esr_mul.sv =====
// ----------------------------------------------------------------------------
// esr_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle and shifts the product right, so
// only an AW-bit adder sits between registers.
// ----------------------------------------------------------------------------
module esr_mul import esr_pkg::*; #(
	parameter int AW = MulAW,
	parameter int BW = MulBW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  seq_ctl_t         ctl,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] prod,
	output logic             done
);

	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] prod_q;
	logic [IterW-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW:0]      sum;

	always_comb begin
		sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			prod_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			a_q    <= a;
			prod_q <= {{AW{1'b0}}, b};
			cnt_q  <= ctl.iters;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[BW-1:1]};
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == IterW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ===== design/esr_div.sv =====
// ----------------------------------------------------------------------------
// esr_div: bit-serial restoring divider
// Shifts one dividend bit per cycle into a remainder that stays below the
// divisor, producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esr_div import esr_pkg::*; #(
	parameter int NW = DivNW,
	parameter int DW = DivDW,
	parameter int QW = DivQW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  seq_ctl_t      ctl,
	input  logic [DW-1:0] rem_init,
	input  logic [NW-1:0] dvd,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          done
);

	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    dvd_q;
	logic [DW-1:0]    den_q;
	logic [QW-1:0]    quo_q;
	logic [IterW-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      trial_sub;
	logic             fits;

	always_comb begin
		trial     = {rem_q, dvd_q[NW-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			rem_q  <= rem_init;
			dvd_q  <= dvd;
			den_q  <= den;
			quo_q  <= '0;
			cnt_q  <= ctl.iters;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
			dvd_q  <= {dvd_q[NW-2:0], 1'b0};
			quo_q  <= {quo_q[QW-2:0], fits};
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == IterW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== design/esc_pulse_slew_and_ramp.sv =====
// ----------------------------------------------------------------------------
// esc_pulse_slew_and_ramp: throttle pulse slew limiter with linear sweep ramp
// A slew request gives its pulse through the 32-step serial multiplier. A
// sweep request takes a serial divide by 1000 alone when the ramp is
// complete, and otherwise a serial divide by 1000, a 12-step multiply and a
// 12-step divide. Stop, hold and the first slew request after reset or stop
// give no pulse. One request is in work at a time. Reset restores every
// register to its reset value at once.
// ----------------------------------------------------------------------------
module esc_pulse_slew_and_ramp import esr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic [1:0]        mode,
	input  logic [TimeW-1:0]  now_us,
	input  logic [TimeW-1:0]  start_us,
	output logic              pulse_valid,
	input  logic              pulse_ready,
	output logic [PulseW-1:0] pulse_us,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLEW_MUL,
		ST_MS_DIV,
		ST_RAMP_MUL,
		ST_RAMP_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [RateW-1:0]    rate_q;
	logic [PulseW-1:0]   target_q;
	logic [PulseW-1:0]   init_q;
	logic [PulseW-1:0]   final_q;
	logic [DurW-1:0]     dur_q;
	logic [AccW-1:0]     speed_q;
	logic [TimeW-1:0]    last_q;
	logic                latched_q;
	logic [AccW-1:0]     dist_q;
	logic                up_q;
	logic [PulseW-1:0]   res_q;
	logic [PulseW-1:0]   pulse_q;
	logic                pulse_valid_q;

	logic                accept;
	logic                cfg_wr;
	logic [AccW-1:0]     goal;
	logic [TimeW-1:0]    delta;
	logic [PulseW:0]     span;
	logic                span_neg;
	logic [PulseW:0]     span_abs;
	logic [PulseW-1:0]   span_mag;
	logic                reach;
	logic [AccW-1:0]     speed_next;
	logic                ramp_over;
	logic [DivNW-1:0]    ramp_prod;
	logic [PulseW-1:0]   ramp_q;
	logic [PulseW-1:0]   ramp_res;

	seq_ctl_t            mul_ctl;
	logic [MulAW-1:0]    mul_a;
	logic [MulBW-1:0]    mul_b;
	logic [MulAW+MulBW-1:0] mul_prod;
	logic                mul_done;

	seq_ctl_t            div_ctl;
	logic [DivDW-1:0]    div_rem;
	logic [DivNW-1:0]    div_dvd;
	logic [DivDW-1:0]    div_den;
	logic [DivQW-1:0]    div_quo;
	logic                div_done;

	assign accept = tick_valid && tick_ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		goal       = {target_q, {FracBits{1'b0}}};
		delta      = now_us - last_q;
		span       = {1'b0, final_q} - {1'b0, init_q};
		span_neg   = span[PulseW];
		span_abs   = span_neg ? -span : span;
		span_mag   = span_abs[PulseW-1:0];
		reach      = (|mul_prod[MulAW+MulBW-1:AccW]) || (mul_prod[AccW-1:0] >= dist_q);
		speed_next = reach ? goal :
			(up_q ? speed_q + mul_prod[AccW-1:0] : speed_q - mul_prod[AccW-1:0]);
		ramp_over  = div_quo >= {{(DivQW-DurW){1'b0}}, dur_q};
		ramp_prod  = mul_prod[DivNW+MulBW-PulseW-1:MulBW-PulseW];
		ramp_q     = div_quo[PulseW-1:0];
		ramp_res   = span_neg ? init_q - ramp_q : init_q + ramp_q;
	end

	always_comb begin
		mul_ctl = '0;
		mul_a   = rate_q;
		mul_b   = delta;
		div_ctl = '0;
		div_rem = '0;
		div_dvd = {now_us - start_us, 2'b00};
		div_den = UsPerMs;
		if (state_q == ST_IDLE) begin
			if (accept && mode_t'(mode) == MODE_SLEW && latched_q) begin
				mul_ctl.start = 1'b1;
				mul_ctl.iters = IterW'(TimeW);
			end
			if (accept && mode_t'(mode) == MODE_SWEEP) begin
				div_ctl.start = 1'b1;
				div_ctl.iters = IterW'(TimeW);
			end
		end else if (state_q == ST_MS_DIV) begin
			mul_a = {{(MulAW-DurW){1'b0}}, div_quo[DurW-1:0]};
			mul_b = {{(MulBW-PulseW){1'b0}}, span_mag};
			if (div_done && !ramp_over) begin
				mul_ctl.start = 1'b1;
				mul_ctl.iters = IterW'(PulseW);
			end
		end else if (state_q == ST_RAMP_MUL) begin
			div_rem = ramp_prod[DivNW-1:PulseW];
			div_dvd = {ramp_prod[PulseW-1:0], {(DivNW-PulseW){1'b0}}};
			div_den = dur_q;
			if (mul_done) begin
				div_ctl.start = 1'b1;
				div_ctl.iters = IterW'(PulseW);
			end
		end
	end

	esr_mul #(
		.AW(MulAW),
		.BW(MulBW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mul_ctl),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (mul_prod),
		.done  (mul_done)
	);

	esr_div #(
		.NW(DivNW),
		.DW(DivDW),
		.QW(DivQW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.rem_init(div_rem),
		.dvd     (div_dvd),
		.den     (div_den),
		.quo     (div_quo),
		.done    (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RateReset;
			target_q <= TargetReset;
			init_q   <= InitialReset;
			final_q  <= FinalReset;
			dur_q    <= DurReset;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[AddrW-1:2]))
				REG_SLEW_RATE: rate_q   <= pwdata[RateW-1:0];
				REG_TARGET:    target_q <= pwdata[PulseW-1:0];
				REG_INITIAL:   init_q   <= pwdata[PulseW-1:0];
				REG_FINAL:     final_q  <= pwdata[PulseW-1:0];
				REG_DURATION:  dur_q    <= pwdata[DurW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[AddrW-1:2]))
			REG_SLEW_RATE: prdata = {{(DataW-RateW){1'b0}}, rate_q};
			REG_TARGET:    prdata = {{(DataW-PulseW){1'b0}}, target_q};
			REG_INITIAL:   prdata = {{(DataW-PulseW){1'b0}}, init_q};
			REG_FINAL:     prdata = {{(DataW-PulseW){1'b0}}, final_q};
			REG_DURATION:  prdata = {{(DataW-DurW){1'b0}}, dur_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			speed_q       <= {IdlePulse, {FracBits{1'b0}}};
			last_q        <= '0;
			latched_q     <= 1'b0;
			dist_q        <= '0;
			up_q          <= 1'b0;
			res_q         <= '0;
			pulse_q       <= '0;
			pulse_valid_q <= 1'b0;
		end else begin
			if (pulse_valid_q && pulse_ready && state_q != ST_DONE) begin
				pulse_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (mode_t'(mode))
							MODE_SLEW: begin
								last_q    <= now_us;
								latched_q <= 1'b1;
								up_q      <= speed_q < goal;
								dist_q    <= (speed_q < goal) ? goal - speed_q : speed_q - goal;
								if (latched_q) begin
									state_q <= ST_SLEW_MUL;
								end
							end
							MODE_SWEEP: state_q <= ST_MS_DIV;
							MODE_STOP: begin
								speed_q   <= {IdlePulse, {FracBits{1'b0}}};
								last_q    <= '0;
								latched_q <= 1'b0;
							end
							MODE_HOLD: ;
						endcase
					end
				end
				ST_SLEW_MUL: begin
					if (mul_done) begin
						speed_q <= speed_next;
						res_q   <= speed_next[AccW-1:FracBits];
						state_q <= ST_DONE;
					end
				end
				ST_MS_DIV: begin
					if (div_done) begin
						if (ramp_over) begin
							res_q   <= final_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RAMP_MUL;
						end
					end
				end
				ST_RAMP_MUL: begin
					if (mul_done) begin
						state_q <= ST_RAMP_DIV;
					end
				end
				ST_RAMP_DIV: begin
					if (div_done) begin
						res_q   <= ramp_res;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!pulse_valid_q || pulse_ready) begin
						pulse_q       <= res_q;
						pulse_valid_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign tick_ready  = state_q == ST_IDLE;
	assign pulse_valid = pulse_valid_q;
	assign pulse_us    = pulse_q;

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_SLEW_MUL || state_q == ST_RAMP_MUL))
		else $error("Multiplier finished outside a multiply state.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_MS_DIV || state_q == ST_RAMP_DIV))
		else $error("Divider finished outside a divide state.");

	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RAMP_DIV && div_done) |->
		(div_quo[PulseW-1:0] <= span_mag && div_quo[DivQW-1:PulseW] == '0))
		else $error("Ramp quotient exceeds the ramp span.");

	a_unlatched_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!latched_q |-> last_q == '0)
		else $error("Latched time is nonzero while no time is latched.");

endmodule
